// ===== src/eci_pkg.sv =====
// Package for the easing curve interpolator: payload types, command codes and fixed-point helpers.
`default_nettype none

package eci_pkg;

    localparam int MAX_EXPONENT = 8;

    localparam int CMD_W  = 3;
    localparam int POS_W  = 32;
    localparam int PROG_W = 17;
    localparam int EXP_W  = 4;
    localparam int OVS_W  = 19;

    localparam int DIFF_W = POS_W + 1;
    localparam int S_W    = PROG_W + 1;   // signed progress, t - 1 for back-out
    localparam int B_W    = 21;           // curve base, about -8.0 .. +9.0
    localparam int R_W    = 31;           // power result, clamped to +-2^29
    localparam int PROD_W = R_W + B_W;
    localparam int ACC_W  = 64;

    localparam logic [PROG_W-1:0]  ONE_Q16  = PROG_W'(65536);
    localparam logic [PROG_W-1:0]  HALF_Q16 = PROG_W'(32768);
    localparam logic signed [ACC_W-1:0] FRAC_LIMIT = 64'sd536870912;

    typedef enum logic [CMD_W-1:0] {
        CMD_LERP     = 3'd0,
        CMD_EASE_IN  = 3'd1,
        CMD_EASE_OUT = 3'd2,
        CMD_IN_OUT   = 3'd3,
        CMD_BACK_IN  = 3'd4,
        CMD_BACK_OUT = 3'd5
    } cmd_t;

    typedef struct packed {
        logic [CMD_W-1:0]         command;
        logic signed [POS_W-1:0]  start_value;
        logic signed [POS_W-1:0]  end_value;
        logic [PROG_W-1:0]        progress;
        logic [EXP_W-1:0]         exponent;
    } eci_in_t;

    typedef struct packed {
        logic signed [POS_W-1:0]  position;
        logic                     saturated;
    } eci_out_t;

    // Everything an item carries down the pipeline; stages use what they need.
    typedef struct packed {
        cmd_t                      cmd;
        logic signed [POS_W-1:0]   a;
        logic signed [DIFF_W-1:0]  diff;
        logic [PROG_W-1:0]         t;
        logic [EXP_W-1:0]          n;
        logic signed [S_W-1:0]     s;
        logic [PROG_W-1:0]         s2;
        logic signed [S_W-1:0]     s3;
        logic signed [B_W-1:0]     ba;
        logic signed [B_W-1:0]     bb;
        logic signed [B_W-1:0]     base;
        logic signed [R_W-1:0]     r;
        logic signed [PROD_W-1:0]  prod;
        logic signed [PROD_W-1:0]  prod2;
        logic signed [ACC_W-1:0]   acc;
        logic                      sat;
    } pipe_t;

    // Q.16 product back to Q.16, round half away from zero.
    function automatic logic signed [ACC_W-1:0] round_q16(input logic signed [ACC_W-1:0] p);
        logic signed [ACC_W-1:0] bias;
        bias = p[ACC_W-1] ? 64'sd32767 : 64'sd32768;
        return (p + bias) >>> 16;
    endfunction

endpackage

`default_nettype wire

// ===== src/easing_curve_interpolator.sv =====
// Throughput: one transfer per cycle while the skid entry is empty; multiplies and rounds sit
// in separate stages, and the power chain takes two stages per exponent step up to MAX_EXPONENT.
// A two-entry output (register plus skid) keeps input moving one item past a stalled output.
// Reset clears all valid bits and the skid entry; overshoot returns to 111514 (about 1.70158).
// No clearing pass: the block accepts input on the first cycle after reset.
`default_nettype none

module easing_curve_interpolator (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_wr_en,
    input  wire logic [eci_pkg::OVS_W-1:0]      cfg_wr_data,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire eci_pkg::eci_in_t               in_data,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output eci_pkg::eci_out_t                   out_data
);
    import eci_pkg::*;

    localparam int ST_IN    = 0;
    localparam int ST_SQ    = 1;
    localparam int ST_SQR   = 2;
    localparam int ST_CUBE  = 3;
    localparam int ST_CUBER = 4;
    localparam int ST_BMUL  = 5;
    localparam int ST_BRND  = 6;
    localparam int ST_BASE  = 7;
    localparam int ST_POW   = 8;
    localparam int ST_FRAC  = ST_POW + 2 * MAX_EXPONENT;
    localparam int ST_FMUL  = ST_FRAC + 1;
    localparam int ST_FSUM  = ST_FMUL + 1;
    localparam int ST_FRND  = ST_FSUM + 1;
    localparam int NSTG     = ST_FRND + 1;

    localparam logic [OVS_W-1:0]        OVS_RESET = OVS_W'(111514);
    localparam logic signed [B_W-1:0]   B_ONE     = B_W'(65536);
    localparam logic signed [B_W-1:0]   B_TWO     = B_W'(131072);
    localparam logic signed [R_W-1:0]   R_ONE     = R_W'(65536);
    localparam logic signed [R_W-1:0]   R_LIMIT   = R_W'(536870912);

    logic [OVS_W-1:0]   overshoot_reg;
    logic [OVS_W:0]     c3;

    pipe_t              st_reg  [NSTG];
    pipe_t              st_next [NSTG];
    logic [NSTG-1:0]    v_reg;
    logic               adv;

    eci_out_t           res;
    eci_out_t           out_reg;
    logic               out_valid_reg;
    eci_out_t           skid_reg;
    logic               skid_valid_reg;

    // ---------------------------------------------------------------- config
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            overshoot_reg <= OVS_RESET;
        end
        else if (cfg_wr_en)
        begin
            overshoot_reg <= cfg_wr_data;
        end
    end

    assign c3 = {1'b0, overshoot_reg} + (OVS_W + 1)'(65536);

    // ---------------------------------------------------------------- stages
    always_comb
    begin : s_in
        logic [PROG_W-1:0] t_c;
        st_next[ST_IN] = '0;
        t_c = (in_data.progress > ONE_Q16) ? ONE_Q16 : in_data.progress;
        if (in_data.command <= CMD_W'(CMD_BACK_OUT))
        begin
            st_next[ST_IN].cmd = cmd_t'(in_data.command);
        end
        else
        begin
            st_next[ST_IN].cmd = CMD_LERP;
        end
        if (int'(in_data.exponent) > MAX_EXPONENT)
        begin
            st_next[ST_IN].n = EXP_W'(MAX_EXPONENT);
        end
        else
        begin
            st_next[ST_IN].n = in_data.exponent;
        end
        st_next[ST_IN].t    = t_c;
        st_next[ST_IN].a    = in_data.start_value;
        st_next[ST_IN].diff = DIFF_W'(in_data.end_value) - DIFF_W'(in_data.start_value);
        if (cmd_t'(st_next[ST_IN].cmd) == CMD_BACK_OUT)
        begin
            st_next[ST_IN].s = signed'({1'b0, t_c}) - S_W'(65536);
        end
        else
        begin
            st_next[ST_IN].s = signed'({1'b0, t_c});
        end
    end

    always_comb
    begin : s_sq
        logic signed [2*S_W-1:0] p;
        p = st_reg[ST_SQ-1].s * st_reg[ST_SQ-1].s;
        st_next[ST_SQ] = st_reg[ST_SQ-1];
        st_next[ST_SQ].prod = PROD_W'(p);
    end

    always_comb
    begin : s_sqr
        logic signed [ACC_W-1:0] rq;
        rq = round_q16(ACC_W'(st_reg[ST_SQR-1].prod));
        st_next[ST_SQR] = st_reg[ST_SQR-1];
        st_next[ST_SQR].s2 = rq[PROG_W-1:0];
    end

    always_comb
    begin : s_cube
        logic signed [2*S_W-1:0] p;
        p = signed'({1'b0, st_reg[ST_CUBE-1].s2}) * st_reg[ST_CUBE-1].s;
        st_next[ST_CUBE] = st_reg[ST_CUBE-1];
        st_next[ST_CUBE].prod = PROD_W'(p);
    end

    always_comb
    begin : s_cuber
        logic signed [ACC_W-1:0] rq;
        rq = round_q16(ACC_W'(st_reg[ST_CUBER-1].prod));
        st_next[ST_CUBER] = st_reg[ST_CUBER-1];
        st_next[ST_CUBER].s3 = rq[S_W-1:0];
    end

    // c3*s^3 and c1*s^2 side by side
    always_comb
    begin : s_bmul
        logic signed [OVS_W+1+S_W-1:0]    pa;
        logic signed [OVS_W+1+PROG_W:0]   pb;
        pa = signed'({1'b0, c3}) * st_reg[ST_BMUL-1].s3;
        pb = signed'({1'b0, overshoot_reg}) * signed'({1'b0, st_reg[ST_BMUL-1].s2});
        st_next[ST_BMUL] = st_reg[ST_BMUL-1];
        st_next[ST_BMUL].prod  = PROD_W'(pa);
        st_next[ST_BMUL].prod2 = PROD_W'(pb);
    end

    always_comb
    begin : s_brnd
        logic signed [ACC_W-1:0] ra;
        logic signed [ACC_W-1:0] rb;
        ra = round_q16(ACC_W'(st_reg[ST_BRND-1].prod));
        rb = round_q16(ACC_W'(st_reg[ST_BRND-1].prod2));
        st_next[ST_BRND] = st_reg[ST_BRND-1];
        st_next[ST_BRND].ba = ra[B_W-1:0];
        st_next[ST_BRND].bb = rb[B_W-1:0];
    end

    always_comb
    begin : s_base
        pipe_t p;
        logic signed [B_W-1:0] t2;
        p  = st_reg[ST_BASE-1];
        t2 = signed'({3'b000, p.t, 1'b0});
        st_next[ST_BASE] = p;
        st_next[ST_BASE].r = R_ONE;
        unique case (p.cmd)
            CMD_EASE_IN:  st_next[ST_BASE].base = signed'({4'b0000, p.t});
            CMD_EASE_OUT: st_next[ST_BASE].base = B_ONE - signed'({4'b0000, p.t});
            CMD_IN_OUT:   st_next[ST_BASE].base = (p.t < HALF_Q16) ? t2 : B_TWO - t2;
            CMD_BACK_IN:  st_next[ST_BASE].base = p.ba - p.bb;
            CMD_BACK_OUT: st_next[ST_BASE].base = B_ONE + p.ba + p.bb;
            default:      st_next[ST_BASE].base = '0;
        endcase
    end

    // power chain: multiply stage, then round and clamp stage, per exponent step
    for (genvar j = 0; j < MAX_EXPONENT; j++)
    begin : g_pow
        localparam int MS = ST_POW + 2 * j;

        always_comb
        begin : mult
            logic signed [PROD_W-1:0] p;
            p = st_reg[MS-1].r * st_reg[MS-1].base;
            st_next[MS] = st_reg[MS-1];
            st_next[MS].prod = p;
        end

        always_comb
        begin : rnd
            logic signed [ACC_W-1:0] rq;
            rq = round_q16(ACC_W'(st_reg[MS].prod));
            st_next[MS+1] = st_reg[MS];
            if (int'(st_reg[MS].n) > j)
            begin
                if (rq > FRAC_LIMIT)
                begin
                    st_next[MS+1].r   = R_LIMIT;
                    st_next[MS+1].sat = 1'b1;
                end
                else if (rq < -FRAC_LIMIT)
                begin
                    st_next[MS+1].r   = -R_LIMIT;
                    st_next[MS+1].sat = 1'b1;
                end
                else
                begin
                    st_next[MS+1].r = rq[R_W-1:0];
                end
            end
        end
    end

    // eased fraction, held in r from here on
    always_comb
    begin : s_frac
        pipe_t p;
        logic signed [R_W-1:0] h;
        p = st_reg[ST_FRAC-1];
        h = (p.r + R_W'(1)) >>> 1;
        st_next[ST_FRAC] = p;
        unique case (p.cmd)
            CMD_EASE_OUT: st_next[ST_FRAC].r = R_ONE - p.r;
            CMD_IN_OUT:   st_next[ST_FRAC].r = (p.t < HALF_Q16) ? h : R_ONE - h;
            CMD_EASE_IN,
            CMD_BACK_IN,
            CMD_BACK_OUT: st_next[ST_FRAC].r = p.r;
            default:      st_next[ST_FRAC].r = signed'({14'b0, p.t});
        endcase
    end

    // f * (end - start) split into the low 16 bits and the signed upper 17 bits of the difference
    always_comb
    begin : s_fmul
        logic signed [R_W+16:0] pl;
        logic signed [R_W+16:0] ph;
        pl = st_reg[ST_FMUL-1].r * signed'({1'b0, st_reg[ST_FMUL-1].diff[15:0]});
        ph = st_reg[ST_FMUL-1].r * signed'(st_reg[ST_FMUL-1].diff[DIFF_W-1:16]);
        st_next[ST_FMUL] = st_reg[ST_FMUL-1];
        st_next[ST_FMUL].prod  = PROD_W'(pl);
        st_next[ST_FMUL].prod2 = PROD_W'(ph);
    end

    always_comb
    begin : s_fsum
        st_next[ST_FSUM] = st_reg[ST_FSUM-1];
        st_next[ST_FSUM].acc = (ACC_W'(st_reg[ST_FSUM-1].prod2) <<< 16)
                               + ACC_W'(st_reg[ST_FSUM-1].prod);
    end

    always_comb
    begin : s_frnd
        st_next[ST_FRND] = st_reg[ST_FRND-1];
        st_next[ST_FRND].acc = round_q16(st_reg[ST_FRND-1].acc);
    end

    always_comb
    begin : s_out
        logic signed [ACC_W-1:0] sum;
        logic fits;
        sum  = ACC_W'(st_reg[NSTG-1].a) + st_reg[NSTG-1].acc;
        fits = (&sum[ACC_W-1:POS_W-1]) || !(|sum[ACC_W-1:POS_W-1]);
        if (fits)
        begin
            res.position = sum[POS_W-1:0];
        end
        else if (sum[ACC_W-1])
        begin
            res.position = {1'b1, {(POS_W-1){1'b0}}};
        end
        else
        begin
            res.position = {1'b0, {(POS_W-1){1'b1}}};
        end
        res.saturated = st_reg[NSTG-1].sat || !fits;
    end

    // ---------------------------------------------------------------- pipeline control
    // the whole pipe moves together; it stops only while the skid entry is full
    assign adv      = !skid_valid_reg;
    assign in_ready = adv;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < NSTG; k++)
            begin
                st_reg[k] <= st_next[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[NSTG-2:0], in_valid};
        end
    end

    // ---------------------------------------------------------------- output + skid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || out_ready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= v_reg[NSTG-1];
            end
        end
        else if (adv && v_reg[NSTG-1])
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || out_ready)
        begin
            out_reg <= skid_valid_reg ? skid_reg : res;
        end
        else if (adv && v_reg[NSTG-1])
        begin
            skid_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

`ifndef SYNTHESIS
    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry full while output empty");

    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !out_ready && v_reg[NSTG-1]))
        else $error("skid entry filled without a stalled output");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (v_reg[NSTG-1] && !adv) |=> (v_reg[NSTG-1] && $stable(st_reg[NSTG-1])))
        else $error("last stage changed during stall");

    a_ease_frac: assert property (@(posedge clk) disable iff (!rst_n)
        (v_reg[ST_FRAC] && (st_reg[ST_FRAC].cmd == CMD_EASE_IN
                            || st_reg[ST_FRAC].cmd == CMD_EASE_OUT
                            || st_reg[ST_FRAC].cmd == CMD_IN_OUT))
        |-> (st_reg[ST_FRAC].r >= 0 && st_reg[ST_FRAC].r <= R_ONE))
        else $error("ease fraction outside zero to one");
`endif

endmodule

`default_nettype wire

// ===== dv/easing_curve_interpolator_tb.sv =====
// Testbench for easing_curve_interpolator: directed and random items against a local predictor.
module easing_curve_interpolator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import eci_pkg::*;

    localparam int     CYCLE_LIMIT  = 100000;
    localparam int     DRAIN_CYCLES = 2 * MAX_EXPONENT + 20;
    localparam int     HOLD_CYCLES  = 200;
    localparam int     IDLE_PCT     = 22;

    localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

    localparam logic [OVS_W-1:0] OVERSHOOT_RESET = 19'd111514;
    localparam logic [OVS_W-1:0] OVERSHOOT_MAX   = 19'd524287;

    localparam logic signed [POS_W-1:0] POS_MAX  = 32'sh7fffffff;
    localparam logic signed [POS_W-1:0] POS_MIN  = 32'sh80000000;
    localparam logic signed [POS_W-1:0] POS_UNIT = 32'sh00010000;

    localparam logic [PROG_W-1:0] PROG_TOP = 17'h1ffff;
    localparam logic [EXP_W-1:0]  EXP_TOP  = 4'hf;

    localparam longint UNIT   = 65536;
    localparam longint OUT_HI = 64'sd2147483647;
    localparam longint OUT_LO = -64'sd2147483648;

    logic     clk;
    logic     rst_n;
    logic     cfg_wr_en;
    logic [OVS_W-1:0] cfg_wr_data;
    logic     in_valid;
    logic     in_ready;
    eci_in_t  in_data;
    logic     out_valid;
    logic     out_ready;
    eci_out_t out_data;

    logic [OVS_W-1:0] overshoot_model;
    eci_out_t         expected_positions[$];
    bit               clip_seen;
    bit               idle_on;
    bit               hold_request;
    int               items_sent;
    int               results_seen;
    int               fail_count;
    int               cycle_count = 0;

    easing_curve_interpolator DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data)
    );

    always #5 clk = ~clk;

    // ---------------- predictor ----------------

    function automatic longint clip_q(input longint v);
        if (v > FRAC_LIMIT)
        begin
            clip_seen = 1'b1;
            return FRAC_LIMIT;
        end
        if (v < -FRAC_LIMIT)
        begin
            clip_seen = 1'b1;
            return -FRAC_LIMIT;
        end
        return v;
    endfunction

    // Q.16 product back to Q.16, half away from zero
    function automatic longint round_q(input longint p);
        longint mag;
        if (p < 0)
        begin
            mag = -p;
            return -((mag + 32768) >>> 16);
        end
        return (p + 32768) >>> 16;
    endfunction

    function automatic longint mul_q(input longint a, input longint b);
        return clip_q(round_q(a * b));
    endfunction

    function automatic longint pow_q(input longint base, input int unsigned n);
        longint acc;
        acc = UNIT;
        base = clip_q(base);
        for (int unsigned i = 0; i < n; i++)
            acc = mul_q(acc, base);
        return acc;
    endfunction

    function automatic eci_out_t predict_position(input eci_in_t item);
        longint      a, b, t, c1, c3, frac, s, s2, s3, r;
        int unsigned n;
        eci_out_t    res;
        clip_seen = 1'b0;
        a  = longint'($signed(item.start_value));
        b  = longint'($signed(item.end_value));
        t  = longint'(item.progress);
        n  = item.exponent;
        c1 = longint'(overshoot_model);
        c3 = c1 + UNIT;
        if (t > UNIT)
            t = UNIT;
        if (n > MAX_EXPONENT)
            n = MAX_EXPONENT;
        case (item.command)
            CMD_EASE_IN:
                frac = pow_q(t, n);
            CMD_EASE_OUT:
                frac = UNIT - pow_q(UNIT - t, n);
            CMD_IN_OUT:
            begin
                if (t < UNIT / 2)
                    frac = (pow_q(2 * t, n) + 1) / 2;
                else
                    frac = UNIT - (pow_q(2 * UNIT - 2 * t, n) + 1) / 2;
            end
            CMD_BACK_IN:
            begin
                s2   = mul_q(t, t);
                s3   = mul_q(s2, t);
                frac = pow_q(mul_q(c3, s3) - mul_q(c1, s2), n);
            end
            CMD_BACK_OUT:
            begin
                s    = t - UNIT;
                s2   = mul_q(s, s);
                s3   = mul_q(s2, s);
                frac = pow_q(UNIT + mul_q(c3, s3) + mul_q(c1, s2), n);
            end
            default:
                frac = t;
        endcase
        frac = clip_q(frac);
        r = a + round_q(frac * (b - a));
        if (r > OUT_HI)
        begin
            r = OUT_HI;
            clip_seen = 1'b1;
        end
        if (r < OUT_LO)
        begin
            r = OUT_LO;
            clip_seen = 1'b1;
        end
        res.position  = r[POS_W-1:0];
        res.saturated = clip_seen;
        return res;
    endfunction

    // ---------------- stimulus helpers ----------------

    function automatic eci_in_t make_item(input logic [CMD_W-1:0] cmd,
                                          input logic signed [POS_W-1:0] from_pos,
                                          input logic signed [POS_W-1:0] to_pos,
                                          input logic [PROG_W-1:0] prog,
                                          input logic [EXP_W-1:0] power);
        eci_in_t it;
        it.command     = cmd;
        it.start_value = from_pos;
        it.end_value   = to_pos;
        it.progress    = prog;
        it.exponent    = power;
        return it;
    endfunction

    function automatic logic signed [POS_W-1:0] random_position();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 40)
            return POS_W'($urandom);
        if (pick < 75)
            return $signed(POS_W'($urandom_range(1 << 24))) - (1 << 23);
        case ($urandom_range(3))
            0: return POS_MAX;
            1: return POS_MIN;
            2: return '0;
            default: return POS_UNIT;
        endcase
    endfunction

    function automatic eci_in_t random_item(input bit back_only);
        eci_in_t     it;
        int unsigned pick;
        pick = $urandom_range(99);
        if (back_only)
            it.command = (pick < 50) ? CMD_BACK_IN : CMD_BACK_OUT;
        else if (pick < 94)
            it.command = CMD_W'($urandom_range(CMD_BACK_OUT));
        else
            it.command = CMD_W'($urandom_range(CMD_SPARE_HI, CMD_SPARE_LO));
        it.start_value = random_position();
        it.end_value   = random_position();
        pick = $urandom_range(99);
        if (pick < 80)
            it.progress = PROG_W'($urandom_range(ONE_Q16));
        else if (pick < 90)
            it.progress = PROG_W'($urandom);
        else
        begin
            case ($urandom_range(3))
                0: it.progress = '0;
                1: it.progress = HALF_Q16 - 1;
                2: it.progress = HALF_Q16;
                default: it.progress = ONE_Q16;
            endcase
        end
        if ($urandom_range(99) < 85)
            it.exponent = EXP_W'($urandom_range(MAX_EXPONENT));
        else
            it.exponent = EXP_W'($urandom_range(EXP_TOP, MAX_EXPONENT + 1));
        return it;
    endfunction

    // valid is only lowered while idling, so back-to-back items never toggle it
    task automatic send_item(input eci_in_t item);
        while (idle_on && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do
            @(posedge clk);
        while (!in_ready);
        items_sent++;
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (results_seen != items_sent)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic load_overshoot(input logic [OVS_W-1:0] value);
        cfg_wr_data <= value;
        cfg_wr_en   <= 1'b1;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        overshoot_model = value;
    endtask

    // ---------------- tests ----------------

    task automatic test_directed_corners();
        send_item(make_item(CMD_LERP, '0, 100 * POS_UNIT, '0, '0));
        send_item(make_item(CMD_LERP, POS_MIN, POS_MAX, ONE_Q16, '0));
        send_item(make_item(CMD_LERP, POS_MAX, POS_MIN, ONE_Q16, EXP_TOP));
        send_item(make_item(CMD_LERP, POS_MIN, POS_MAX, HALF_Q16, 4'd3));
        send_item(make_item(CMD_LERP, '0, POS_UNIT, PROG_TOP, '0));
        send_item(make_item(CMD_EASE_IN, '0, 50 * POS_UNIT, 17'd16384, '0));
        send_item(make_item(CMD_EASE_IN, -POS_UNIT, POS_MAX, ONE_Q16 - 1, 4'd8));
        send_item(make_item(CMD_EASE_IN, POS_MAX, -POS_UNIT, 17'd40000, EXP_TOP));
        send_item(make_item(CMD_EASE_OUT, '0, 10 * POS_UNIT, 17'd16384, 4'd3));
        send_item(make_item(CMD_EASE_OUT, POS_MIN, POS_MAX, '0, '0));
        send_item(make_item(CMD_EASE_OUT, POS_MAX, POS_MIN, ONE_Q16, 4'd8));
        send_item(make_item(CMD_IN_OUT, '0, 1000 * POS_UNIT, HALF_Q16 - 1, 4'd2));
        send_item(make_item(CMD_IN_OUT, '0, 1000 * POS_UNIT, HALF_Q16, 4'd2));
        send_item(make_item(CMD_IN_OUT, POS_MIN, POS_MAX, 17'd10000, '0));
        send_item(make_item(CMD_IN_OUT, -POS_UNIT, POS_UNIT, ONE_Q16, 4'd5));
        send_item(make_item(CMD_BACK_IN, '0, 300 * POS_UNIT, ONE_Q16, 4'd1));
        send_item(make_item(CMD_BACK_IN, '0, 300 * POS_UNIT, 17'd20000, 4'd1));
        send_item(make_item(CMD_BACK_IN, POS_MIN, POS_MAX, 17'd20000, 4'd1));
        send_item(make_item(CMD_BACK_IN, POS_UNIT, POS_MIN, '0, 4'd8));
        send_item(make_item(CMD_BACK_OUT, '0, 300 * POS_UNIT, '0, 4'd1));
        send_item(make_item(CMD_BACK_OUT, POS_MAX, POS_MIN, 17'd45000, 4'd1));
        send_item(make_item(CMD_BACK_OUT, -POS_UNIT, 7 * POS_UNIT, 17'd50000, EXP_TOP));
        send_item(make_item(CMD_SPARE_LO, '0, 64 * POS_UNIT, 17'd20000, 4'd4));
        send_item(make_item(CMD_SPARE_HI, POS_MAX, POS_MIN, PROG_TOP, EXP_TOP));
        wait_idle();
    endtask

    task automatic test_overshoot_sweep();
        logic [OVS_W-1:0] settings[3];
        settings[0] = '0;
        settings[1] = OVERSHOOT_MAX;
        settings[2] = OVS_W'($urandom);
        foreach (settings[k])
        begin
            load_overshoot(settings[k]);
            send_item(make_item(CMD_BACK_IN, POS_MIN, POS_MAX, ONE_Q16, 4'd1));
            send_item(make_item(CMD_BACK_IN, POS_MAX, POS_MIN, 17'd38000, 4'd8));
            send_item(make_item(CMD_BACK_OUT, POS_MIN, POS_MAX, '0, 4'd8));
            send_item(make_item(CMD_BACK_OUT, POS_MAX, POS_MIN, 17'd26000, 4'd8));
            repeat (20) send_item(random_item(1'b1));
            wait_idle();
        end
    endtask

    task automatic test_random_traffic();
        load_overshoot(OVERSHOOT_RESET);
        repeat (214) send_item(random_item(1'b0));
        // long stretch at full rate on both sides
        idle_on = 1'b0;
        repeat (80) send_item(random_item(1'b0));
        idle_on = 1'b1;
        wait_idle();
    endtask

    task automatic test_output_stall();
        load_overshoot(OVS_W'($urandom));
        hold_request = 1'b1;
        idle_on      = 1'b0;
        repeat (60) send_item(random_item(1'b0));
        idle_on = 1'b1;
        wait_idle();
    endtask

    // ---------------- receiver and checking ----------------

    initial
    begin : receiver
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            out_ready <= !idle_on || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            expected_positions.push_back(predict_position(in_data));
    end

    always @(posedge clk)
    begin : check_results
        eci_out_t want;
        if (out_valid && out_ready)
        begin
            results_seen++;
            if (expected_positions.size() == 0)
            begin
                $error("position: no transfer pending, actual %0d", $signed(out_data.position));
                fail_count++;
            end
            else
            begin
                want = expected_positions.pop_front();
                if (out_data.position !== want.position)
                begin
                    $error("position: expected %0d, actual %0d",
                           $signed(want.position), $signed(out_data.position));
                    fail_count++;
                end
                if (out_data.saturated !== want.saturated)
                begin
                    $error("saturated: expected %0b, actual %0b",
                           want.saturated, out_data.saturated);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ---------------- sequence ----------------

    initial
    begin
        clk             = 1'b0;
        rst_n           = 1'b0;
        cfg_wr_en       = 1'b0;
        cfg_wr_data     = '0;
        in_valid        = 1'b0;
        in_data         = '0;
        out_ready       = 1'b0;
        overshoot_model = OVERSHOOT_RESET;
        idle_on         = 1'b1;
        hold_request    = 1'b0;
        items_sent      = 0;
        results_seen    = 0;
        fail_count      = 0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_corners();
        test_overshoot_sweep();
        test_random_traffic();
        test_output_stall();

        if (expected_positions.size() != 0)
        begin
            $error("position: %0d transfers never produced a result", expected_positions.size());
            fail_count++;
        end
        if (fail_count == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
